// ----- sv/attitude_horizon_pixel_generator_core_defines.svh -----
// ----------------------------------------------------------------------------
// attitude horizon pixel generator assertion macros
// shared checking macros for the pixel generator core
// ----------------------------------------------------------------------------
`ifndef ATTITUDE_HORIZON_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define ATTITUDE_HORIZON_PIXEL_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define AHPG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AHPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ahpg_pkg.sv -----
// ----------------------------------------------------------------------------
// ahpg_pkg
// geometry constants, register indexes and types of the pixel generator
// ----------------------------------------------------------------------------
package ahpg_pkg;

	localparam int DISPLAY_WIDTH  = 240;
	localparam int DISPLAY_HEIGHT = 240;
	localparam int CX             = DISPLAY_WIDTH / 2;
	localparam int CY             = DISPLAY_HEIGHT / 2;
	localparam int RING_GAP       = 2;
	localparam int RADIUS         = CX - RING_GAP;
	localparam int RAD_OUTER_SQ   = RADIUS * RADIUS;
	localparam int RAD_INNER_SQ   = (RADIUS - RING_GAP) * (RADIUS - RING_GAP);
	localparam int MARK_FAR       = 20;
	localparam int MARK_NEAR      = 19;
	localparam int DEN_MIN        = 13421773;

	localparam logic [2:0] REG_COS_PITCH    = 3'd0;
	localparam logic [2:0] REG_SIN_PITCH    = 3'd1;
	localparam logic [2:0] REG_COS_ROLL     = 3'd2;
	localparam logic [2:0] REG_SIN_ROLL     = 3'd3;
	localparam logic [2:0] REG_SKY_COLOR    = 3'd4;
	localparam logic [2:0] REG_GROUND_COLOR = 3'd5;
	localparam logic [2:0] REG_LINE_COLOR   = 3'd6;
	localparam logic [2:0] REG_RING_COLOR   = 3'd7;

	localparam logic signed [15:0] TRIG_ONE = 16'sd16384;

	typedef logic [15:0] color_t;

	typedef struct packed {
		logic black;
		logic ring;
		logic mark;
		logic den_small;
		logic py_near;
		logic lo_le0;
		logic hi_lt0;
	} flags_t;

endpackage

// ----- sv/ahpg_if.sv -----
// ----------------------------------------------------------------------------
// ahpg interfaces
// valid/ready channels for pixel coordinates and pixel colors
// ----------------------------------------------------------------------------
interface ahpg_coord_if;
	logic       valid;
	logic       ready;
	logic [7:0] x_pos;
	logic [7:0] y_pos;
	modport source (output valid, output x_pos, output y_pos, input ready);
	modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

interface ahpg_color_if;
	logic                 valid;
	logic                 ready;
	ahpg_pkg::color_t     pixel_color;
	modport source (output valid, output pixel_color, input ready);
	modport sink (input valid, input pixel_color, output ready);
endinterface

// ----- sv/attitude_horizon_pixel_generator_core.sv -----
// ----------------------------------------------------------------------------
// attitude_horizon_pixel_generator_core
// Turns a pixel coordinate into its attitude indicator colour. Takes one item
// per clock unless the output stalls, and the five stages are set
// by the chain of multiplies (trig products, rotation, horizon offset test,
// pitched height and divisor bounds). Each stage holds its item while the
// next one is full, so a stalled output does not block earlier empty stages.
// The user must write configuration only while no item is in flight (not enforced).
// ----------------------------------------------------------------------------
`include "attitude_horizon_pixel_generator_core_defines.svh"

module attitude_horizon_pixel_generator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	ahpg_coord_if.sink          pix_in,
	ahpg_color_if.source        pix_out
);

	logic signed [15:0] cos_pitch_q, sin_pitch_q, cos_roll_q, sin_roll_q;
	ahpg_pkg::color_t   sky_color_q, ground_color_q, line_color_q, ring_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_pitch_q    <= ahpg_pkg::TRIG_ONE;
			sin_pitch_q    <= '0;
			cos_roll_q     <= ahpg_pkg::TRIG_ONE;
			sin_roll_q     <= '0;
			sky_color_q    <= '0;
			ground_color_q <= '0;
			line_color_q   <= '0;
			ring_color_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ahpg_pkg::REG_COS_PITCH:    cos_pitch_q    <= cfg_data;
				ahpg_pkg::REG_SIN_PITCH:    sin_pitch_q    <= cfg_data;
				ahpg_pkg::REG_COS_ROLL:     cos_roll_q     <= cfg_data;
				ahpg_pkg::REG_SIN_ROLL:     sin_roll_q     <= cfg_data;
				ahpg_pkg::REG_SKY_COLOR:    sky_color_q    <= cfg_data;
				ahpg_pkg::REG_GROUND_COLOR: ground_color_q <= cfg_data;
				ahpg_pkg::REG_LINE_COLOR:   line_color_q   <= cfg_data;
				ahpg_pkg::REG_RING_COLOR:   ring_color_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || pix_out.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pix_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix_in.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: offsets and products
	logic signed [8:0]  px_c, py_c;
	logic signed [17:0] sqx_c, sqy_c;
	logic               off_c;

	assign px_c  = $signed({1'b0, pix_in.x_pos} - 9'(ahpg_pkg::CX));
	assign py_c  = $signed({1'b0, pix_in.y_pos} - 9'(ahpg_pkg::CY));
	assign sqx_c = px_c * px_c;
	assign sqy_c = py_c * py_c;
	assign off_c = ({3'b0, pix_in.x_pos} >= 11'(ahpg_pkg::DISPLAY_WIDTH))
		|| ({3'b0, pix_in.y_pos} >= 11'(ahpg_pkg::DISPLAY_HEIGHT));

	logic signed [8:0]  px_s1, py_s1;
	logic               off_s1;
	logic [16:0]        d2_s1;
	logic signed [31:0] crcp_s1, srsp_s1, crsp_s1, srcp_s1;
	logic signed [24:0] pxcr_s1, pysr_s1, pycr_s1, pxsr_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			px_s1   <= px_c;
			py_s1   <= py_c;
			off_s1  <= off_c;
			d2_s1   <= 17'(sqx_c) + 17'(sqy_c);
			crcp_s1 <= cos_roll_q * cos_pitch_q;
			srsp_s1 <= sin_roll_q * sin_pitch_q;
			crsp_s1 <= cos_roll_q * sin_pitch_q;
			srcp_s1 <= sin_roll_q * cos_pitch_q;
			pxcr_s1 <= px_c * cos_roll_q;
			pysr_s1 <= py_c * sin_roll_q;
			pycr_s1 <= py_c * cos_roll_q;
			pxsr_s1 <= px_c * sin_roll_q;
		end
	end

	// stage 2: sums, disc and mark tests
	logic signed [8:0]  px_s2, py_s2;
	logic               black_s2, ring_s2, mark_s2;
	logic signed [32:0] den_s2, num_s2;
	logic signed [25:0] xr_s2, yr_s2;
	logic               mark_c;

	assign mark_c = ((py_s1 == 9'sd0) && ((px_s1 == -9'(ahpg_pkg::MARK_FAR))
		|| (px_s1 == -9'(ahpg_pkg::MARK_NEAR)) || (px_s1 == 9'(ahpg_pkg::MARK_NEAR))
		|| (px_s1 == 9'(ahpg_pkg::MARK_FAR)) || (px_s1 == 9'sd0)))
		|| ((px_s1 == 9'sd0) && (py_s1 == -9'sd1));

	always_ff @(posedge clk) begin
		if (rdy2) begin
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			black_s2 <= off_s1 || (d2_s1 > 17'(ahpg_pkg::RAD_OUTER_SQ));
			ring_s2  <= d2_s1 > 17'(ahpg_pkg::RAD_INNER_SQ);
			mark_s2  <= mark_c;
			den_s2   <= 33'(crcp_s1) - 33'(srsp_s1);
			num_s2   <= 33'(crsp_s1) + 33'(srcp_s1);
			xr_s2    <= 26'(pxcr_s1) + 26'(pysr_s1);
			yr_s2    <= 26'(pycr_s1) - 26'(pxsr_s1);
		end
	end

	// stage 3: horizon product, pitch products, offset bounds
	logic [32:0]        den_abs_c;
	logic signed [9:0]  t_c, lo_c, hi_c, hi1_c;
	logic               neg_c;

	assign den_abs_c = den_s2[32] ? 33'(-den_s2) : 33'(den_s2);
	assign neg_c     = px_s2[8] ^ num_s2[32] ^ den_s2[32];
	assign t_c       = neg_c ? -10'(py_s2) : 10'(py_s2);
	assign lo_c      = t_c - 10'sd1;
	assign hi_c      = t_c + 10'sd1;
	assign hi1_c     = t_c + 10'sd2;

	ahpg_pkg::flags_t   flags_s3;
	logic signed [41:0] p_s3, ypa_s3, ypb_s3;
	logic [31:0]        b_s3;
	logic [7:0]         lo8_s3, hi8_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			flags_s3.black     <= black_s2;
			flags_s3.ring      <= ring_s2;
			flags_s3.mark      <= mark_s2;
			flags_s3.den_small <= den_abs_c < 33'(ahpg_pkg::DEN_MIN);
			flags_s3.py_near   <= (py_s2 >= -9'sd1) && (py_s2 <= 9'sd1);
			flags_s3.lo_le0    <= lo_c <= 10'sd0;
			flags_s3.hi_lt0    <= hi_c < 10'sd0;
			p_s3   <= px_s2 * num_s2;
			ypa_s3 <= yr_s2 * cos_pitch_q;
			ypb_s3 <= xr_s2 * sin_pitch_q;
			b_s3   <= den_abs_c[31:0];
			lo8_s3 <= lo_c[7:0];
			hi8_s3 <= hi1_c[7:0];
		end
	end

	// stage 4: magnitude, divisor bounds, sky test
	ahpg_pkg::flags_t   flags_s4;
	logic [40:0]        a_s4;
	logic [39:0]        mlo_s4, mhi_s4;
	logic               yneg_s4;
	logic signed [42:0] yp_c;
	logic [41:0]        p_abs_c;

	assign yp_c    = 43'(ypa_s3) - 43'(ypb_s3);
	assign p_abs_c = p_s3[41] ? 42'(-p_s3) : 42'(p_s3);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			flags_s4 <= flags_s3;
			a_s4     <= p_abs_c[40:0];
			mlo_s4   <= lo8_s3 * b_s3;
			mhi_s4   <= hi8_s3 * b_s3;
			yneg_s4  <= yp_c[42];
		end
	end

	// stage 5: colour select
	logic             line_c;
	ahpg_pkg::color_t color_c, pixel_color_s5;

	assign line_c = flags_s4.den_small ? flags_s4.py_near
		: ((flags_s4.lo_le0 || (a_s4 >= 41'(mlo_s4)))
			&& !flags_s4.hi_lt0 && (a_s4 < 41'(mhi_s4)));

	always_comb begin
		if (flags_s4.black) begin
			color_c = '0;
		end else if (flags_s4.ring) begin
			color_c = ring_color_q;
		end else if (line_c || flags_s4.mark) begin
			color_c = line_color_q;
		end else if (yneg_s4) begin
			color_c = sky_color_q;
		end else begin
			color_c = ground_color_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			pixel_color_s5 <= color_c;
		end
	end

	assign pix_out.valid       = v_s5;
	assign pix_out.pixel_color = pixel_color_s5;

	`AHPG_ASSERT_NEXT(a_accept_fills, pix_in.valid && pix_in.ready, v_s1, "accepted item lost")
	`AHPG_ASSERT_NEXT(a_s4_holds, v_s4 && !rdy5, v_s4, "stalled item dropped")
	`AHPG_ASSERT_NEXT(a_black_out, v_s4 && rdy5 && flags_s4.black,
		pix_out.valid && (pix_out.pixel_color == '0), "outside pixel not black")
	`AHPG_ASSERT_NOW(a_ready_chain, v_s5 && !pix_out.ready && v_s4 && v_s3 && v_s2 && v_s1,
		!pix_in.ready, "full pipeline took an item")

endmodule

// ----- tb/sv/ahpg_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ahpg testbench channel note
// the channel interfaces come from the rtl file ahpg_if.sv; this file only
// holds the shared record of one pixel item used by the checker
// ----------------------------------------------------------------------------
package ahpg_tb_pkg;

	typedef struct packed {
		logic [7:0] x_pos;
		logic [7:0] y_pos;
	} pixel_item_t;

endpackage

// ----- tb/sv/attitude_horizon_pixel_generator_core_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attitude_horizon_pixel_generator_core_checker
// Watches the coordinate and colour channels, predicts each colour from its
// own copy of the registers and compares in order.
// ----------------------------------------------------------------------------
module attitude_horizon_pixel_generator_core_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        x_pos,
	input  logic [7:0]        y_pos,
	input  logic              out_valid,
	input  logic              out_ready,
	input  ahpg_pkg::color_t  pixel_color,
	output int                fail_count,
	output int                pending,
	output int                colours_seen
);

	logic signed [15:0] cp, sp, cr, sr;
	ahpg_pkg::color_t sky, ground, line_c, ring;
	ahpg_pkg::color_t colour_q[$];

	function automatic ahpg_pkg::color_t shade_pixel(ahpg_tb_pkg::pixel_item_t it);
		longint px, py, d2, den, num, off, rel, xr, yr, yp;
		px = longint'(it.x_pos) - ahpg_pkg::CX;
		py = longint'(it.y_pos) - ahpg_pkg::CY;
		d2 = px * px + py * py;
		if (it.x_pos >= ahpg_pkg::DISPLAY_WIDTH || it.y_pos >= ahpg_pkg::DISPLAY_HEIGHT)
			return '0;
		if (d2 > ahpg_pkg::RAD_OUTER_SQ) return '0;
		if (d2 > ahpg_pkg::RAD_INNER_SQ) return ring;
		den = longint'(cr) * cp - longint'(sr) * sp;
		num = longint'(cr) * sp + longint'(sr) * cp;
		off = 0;
		if ((den < 0 ? -den : den) >= ahpg_pkg::DEN_MIN) off = (px * num) / den;
		rel = longint'(it.y_pos) - (ahpg_pkg::CY + off);
		if (rel >= -1 && rel <= 1) return line_c;
		if (it.y_pos == ahpg_pkg::CY && (px == -ahpg_pkg::MARK_FAR
				|| px == -ahpg_pkg::MARK_NEAR || px == ahpg_pkg::MARK_NEAR
				|| px == ahpg_pkg::MARK_FAR || px == 0)) return line_c;
		if (it.x_pos == ahpg_pkg::CX && it.y_pos == ahpg_pkg::CY - 1) return line_c;
		xr = px * cr + py * sr;
		yr = py * cr - px * sr;
		yp = yr * cp - xr * sp;
		return yp < 0 ? sky : ground;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp <= ahpg_pkg::TRIG_ONE;
			sp <= '0;
			cr <= ahpg_pkg::TRIG_ONE;
			sr <= '0;
			sky <= '0;
			ground <= '0;
			line_c <= '0;
			ring <= '0;
			colour_q.delete();
			fail_count = 0;
			colours_seen = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ahpg_pkg::REG_COS_PITCH: cp <= cfg_data;
					ahpg_pkg::REG_SIN_PITCH: sp <= cfg_data;
					ahpg_pkg::REG_COS_ROLL: cr <= cfg_data;
					ahpg_pkg::REG_SIN_ROLL: sr <= cfg_data;
					ahpg_pkg::REG_SKY_COLOR: sky <= cfg_data;
					ahpg_pkg::REG_GROUND_COLOR: ground <= cfg_data;
					ahpg_pkg::REG_LINE_COLOR: line_c <= cfg_data;
					ahpg_pkg::REG_RING_COLOR: ring <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				colour_q.push_back(shade_pixel({x_pos, y_pos}));
			if (out_valid && out_ready) begin
				colours_seen++;
				if (colour_q.size() == 0)
					report_mismatch("colour item with nothing expected");
				else begin
					ahpg_pkg::color_t want;
					want = colour_q.pop_front();
					if (pixel_color !== want)
						report_mismatch($sformatf("pixel_color %h, expected %h",
							pixel_color, want));
				end
			end
			pending = colour_q.size();
		end
	end

endmodule

// ----- tb/sv/attitude_horizon_pixel_generator_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// attitude_horizon_pixel_generator_core_tb
// Drives pixel coordinates in bursts under several attitude and colour
// settings, including degenerate divisors and out of range trig values, with
// a stalling colour receiver; the checker predicts and compares every colour.
// ----------------------------------------------------------------------------
module attitude_horizon_pixel_generator_core_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int fail_count, pending, colours_seen;
	int sent = 0;
	int stall_mode = 0;

	ahpg_coord_if pix_in ();
	ahpg_color_if pix_out ();

	attitude_horizon_pixel_generator_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_in(pix_in.sink), .pix_out(pix_out.source)
	);

	attitude_horizon_pixel_generator_core_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(pix_in.valid), .in_ready(pix_in.ready),
		.x_pos(pix_in.x_pos), .y_pos(pix_in.y_pos), .out_valid(pix_out.valid),
		.out_ready(pix_out.ready), .pixel_color(pix_out.pixel_color),
		.fail_count(fail_count), .pending(pending), .colours_seen(colours_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		pix_in.valid = 1'b0;
		pix_in.x_pos = '0;
		pix_in.y_pos = '0;
		pix_out.ready = 1'b0;
	end

	// receiver stall pattern changes with stall_mode
	always @(posedge clk) begin
		case (stall_mode)
			0: pix_out.ready <= 1'b1;
			1: pix_out.ready <= ($urandom_range(0, 3) != 0);
			default: pix_out.ready <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// valid stays high between consecutive items of a burst
	task automatic send_pixel(logic [7:0] xv, logic [7:0] yv, bit keep);
		pix_in.valid <= 1'b1;
		pix_in.x_pos <= xv;
		pix_in.y_pos <= yv;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		sent++;
		if (!keep) pix_in.valid <= 1'b0;
	endtask

	task automatic set_attitude(logic [15:0] c_p, logic [15:0] s_p, logic [15:0] c_r,
			logic [15:0] s_r);
		write_reg(ahpg_pkg::REG_COS_PITCH, c_p);
		write_reg(ahpg_pkg::REG_SIN_PITCH, s_p);
		write_reg(ahpg_pkg::REG_COS_ROLL, c_r);
		write_reg(ahpg_pkg::REG_SIN_ROLL, s_r);
	endtask

	task automatic random_phase(int n);
		int left, burst, gap;
		bit keep;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			if (burst > left) burst = left;
			gap = ($urandom_range(0, 2) != 0) ? int'($urandom_range(1, 5)) : 0;
			for (int i = 0; i < burst; i++) begin
				logic [7:0] xv, yv;
				case ($urandom_range(0, 3))
					0: begin
						xv = 8'($urandom);
						yv = 8'($urandom);
					end
					1: begin
						xv = 8'(ahpg_pkg::CX + $urandom_range(0, 6) - 3);
						yv = 8'($urandom_range(0, 239));
					end
					2: begin
						xv = 8'($urandom_range(0, 239));
						yv = 8'(ahpg_pkg::CY + $urandom_range(0, 6) - 3);
					end
					default: begin
						xv = 8'($urandom_range(0, 239));
						yv = 8'($urandom_range(0, 239));
					end
				endcase
				keep = (i != burst - 1) || (gap == 0 && left > burst);
				send_pixel(xv, yv, keep);
			end
			left -= burst;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic [7:0] cx8, cy8;
		cx8 = 8'(ahpg_pkg::CX);
		cy8 = 8'(ahpg_pkg::CY);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(ahpg_pkg::REG_SKY_COLOR, 16'h001f);
		write_reg(ahpg_pkg::REG_GROUND_COLOR, 16'hf800);
		write_reg(ahpg_pkg::REG_LINE_COLOR, 16'hffff);
		write_reg(ahpg_pkg::REG_RING_COLOR, 16'h07e0);
		// field extremes, ring band, disc edge, centre and aircraft mark
		send_pixel(8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd255, 1'b1);
		send_pixel(8'd239, 8'd120, 1'b1);
		send_pixel(8'd120, 8'd2, 1'b1);
		send_pixel(8'd3, 8'd120, 1'b1);
		send_pixel(8'd120, 8'd4, 1'b1);
		send_pixel(cx8, cy8, 1'b1);
		send_pixel(cx8, cy8 - 8'd1, 1'b1);
		send_pixel(cx8 - 8'd20, cy8, 1'b1);
		send_pixel(cx8 - 8'd19, cy8, 1'b1);
		send_pixel(cx8 + 8'd19, cy8, 1'b1);
		send_pixel(cx8 + 8'd20, cy8, 1'b1);
		send_pixel(cx8 + 8'd30, cy8 + 8'd1, 1'b1);
		send_pixel(cx8 + 8'd30, cy8 + 8'd2, 1'b1);
		send_pixel(cx8 + 8'd30, cy8 - 8'd2, 1'b0);
		drain();
		// vertical divisor: offset forced to zero
		set_attitude(16'h0000, 16'h4000, 16'h4000, 16'h0000);
		send_pixel(8'd60, cy8, 1'b1);
		send_pixel(8'd60, 8'd60, 1'b1);
		send_pixel(8'd180, 8'd180, 1'b0);
		drain();
		stall_mode = 1;
		set_attitude(16'h2d41, 16'h2d41, 16'h3b21, 16'h187e);
		random_phase(120);
		drain();
		stall_mode = 2;
		set_attitude(16'h8000, 16'h7fff, 16'hc000, 16'h8001);
		write_reg(ahpg_pkg::REG_SKY_COLOR, 16'h0000);
		write_reg(ahpg_pkg::REG_RING_COLOR, 16'hffff);
		random_phase(120);
		drain();
		stall_mode = 0;
		set_attitude(16'hc000, 16'h0000, 16'h4000, 16'h0000);
		write_reg(ahpg_pkg::REG_GROUND_COLOR, 16'h0000);
		write_reg(ahpg_pkg::REG_LINE_COLOR, 16'h5555);
		random_phase(100);
		drain();
		stall_mode = 1;
		for (int k = 0; k < 4; k++) begin
			set_attitude(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			write_reg(ahpg_pkg::REG_SKY_COLOR, 16'($urandom));
			write_reg(ahpg_pkg::REG_GROUND_COLOR, 16'($urandom));
			write_reg(ahpg_pkg::REG_LINE_COLOR, 16'($urandom));
			write_reg(ahpg_pkg::REG_RING_COLOR, 16'($urandom));
			stall_mode = k % 3;
			random_phase(55);
			drain();
		end
		$display("sent %0d pixel items, checked %0d colours", sent, colours_seen);
		$display("covered level, rolled, inverted, vertical and out of range attitudes");
		if (fail_count == 0) begin
			$display("attitude_horizon_pixel_generator_core: match");
		end else begin
			$display("attitude_horizon_pixel_generator_core: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("attitude_horizon_pixel_generator_core: mismatch");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ahpg_pkg.sv
sv/ahpg_if.sv
sv/attitude_horizon_pixel_generator_core.sv
tb/sv/ahpg_tb_if.sv
tb/sv/attitude_horizon_pixel_generator_core_checker.sv
tb/sv/attitude_horizon_pixel_generator_core_tb.sv
